>>> hw/rtl/button_press_classifier_defines.svh
// assertion macros for the button press classifier
// used by the top level only; expects clk and rst_n in scope
`ifndef BUTTON_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_DEFINES_SVH

`ifndef SYNTH
`define BPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BPC_ASSERT_SAME(lbl, ante, cons, msg)
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/bpc_pkg.sv
// shared types and constants for the button press classifier
// no dependencies
`default_nettype none

package bpc_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebW      = 16;
  localparam int unsigned LongW     = 16;
  localparam int unsigned VeryW     = 20;
  localparam int unsigned CfgDataW  = 20;
  localparam int unsigned CfgIndexW = 2;

  localparam logic [DebW-1:0]  DEBOUNCE_RESET  = 16'd25;
  localparam logic [LongW-1:0] LONG_RESET      = 16'd750;
  localparam logic [VeryW-1:0] VERY_LONG_RESET = 20'd3000;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_DEBOUNCE  = 2'd0,
    CFG_LONG      = 2'd1,
    CFG_VERY_LONG = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [DebW-1:0]  debounce_time;
    logic [LongW-1:0] long_press_time;
    logic [VeryW-1:0] very_long_press_time;
  } cfg_t;

  typedef struct packed {
    logic             raw_level;
    logic [TimeW-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic very_long_press;
    logic stable_level;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/bpc_channels.sv
// valid/ready channel interfaces for sample words and result words
// depends on bpc_pkg
`default_nettype none

interface bpc_in_if;
  import bpc_pkg::*;

  logic             valid;
  logic             ready;
  logic             raw_level;
  logic [TimeW-1:0] now_time;

  modport source (output valid, output raw_level, output now_time, input ready);
  modport sink   (input valid, input raw_level, input now_time, output ready);
endinterface

interface bpc_out_if;
  logic valid;
  logic ready;
  logic short_press;
  logic long_press;
  logic very_long_press;
  logic stable_level;

  modport source (output valid, output short_press, output long_press,
                  output very_long_press, output stable_level, input ready);
  modport sink   (input valid, input short_press, input long_press,
                  input very_long_press, input stable_level, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bpc_cfg_regs.sv
// configuration registers: debounce, long and very-long thresholds
// depends on bpc_pkg
`default_nettype none

module bpc_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [bpc_pkg::CfgIndexW-1:0]  wr_index,
  input  wire logic [bpc_pkg::CfgDataW-1:0]   wr_data,
  output bpc_pkg::cfg_t                       cfg
);
  import bpc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_index_t'(wr_index))
        CFG_DEBOUNCE:  cfg_nxt.debounce_time        = wr_data[DebW-1:0];
        CFG_LONG:      cfg_nxt.long_press_time      = wr_data[LongW-1:0];
        CFG_VERY_LONG: cfg_nxt.very_long_press_time = wr_data[VeryW-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time        <= DEBOUNCE_RESET;
      cfg_r.long_press_time      <= LONG_RESET;
      cfg_r.very_long_press_time <= VERY_LONG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> hw/rtl/bpc_classify.sv
// debounce and press classification state with its next-state logic
// depends on bpc_pkg
`default_nettype none

module bpc_classify (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire bpc_pkg::cfg_t     cfg,
  input  wire bpc_pkg::in_item_t item,
  output bpc_pkg::out_item_t     result
);
  import bpc_pkg::*;

  logic             last_raw_r;
  logic             debounced_r;
  logic [TimeW-1:0] change_stamp_r;
  logic [TimeW-1:0] press_stamp_r;
  logic             vl_reported_r;

  logic             debounced_nxt;
  logic [TimeW-1:0] change_stamp_nxt;
  logic [TimeW-1:0] press_stamp_nxt;
  logic             vl_reported_nxt;

  logic [TimeW-1:0] since_change;
  logic [TimeW-1:0] held;
  logic             settled;
  logic             take;
  logic             press_begin;
  logic             release_ev;
  logic             vl_cleared;
  logic             reached_very;
  logic             reached_long;
  logic             ev_very;

  always_comb begin
    change_stamp_nxt = (item.raw_level != last_raw_r) ? item.now_time : change_stamp_r;
    since_change     = item.now_time - change_stamp_nxt;
    settled          = since_change >= {{(TimeW-DebW){1'b0}}, cfg.debounce_time};
    take             = settled && (debounced_r != item.raw_level);
    press_begin      = take && item.raw_level;
    release_ev       = take && !item.raw_level && !vl_reported_r;

    debounced_nxt    = take ? item.raw_level : debounced_r;
    press_stamp_nxt  = press_begin ? item.now_time : press_stamp_r;
    vl_cleared       = press_begin ? 1'b0 : vl_reported_r;

    // hold time against the old press stamp; a new press has held zero
    held             = item.now_time - press_stamp_r;
    reached_long     = held >= {{(TimeW-LongW){1'b0}}, cfg.long_press_time};
    reached_very     = press_begin
                       ? (cfg.very_long_press_time == '0)
                       : (held >= {{(TimeW-VeryW){1'b0}}, cfg.very_long_press_time});
    ev_very          = debounced_nxt && !vl_cleared && reached_very;
    vl_reported_nxt  = vl_cleared || ev_very;

    result.short_press     = release_ev && !reached_long;
    result.long_press      = release_ev && reached_long;
    result.very_long_press = ev_very;
    result.stable_level    = debounced_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r     <= 1'b0;
      debounced_r    <= 1'b0;
      change_stamp_r <= '0;
      press_stamp_r  <= '0;
      vl_reported_r  <= 1'b0;
    end else if (step) begin
      last_raw_r     <= item.raw_level;
      debounced_r    <= debounced_nxt;
      change_stamp_r <= change_stamp_nxt;
      press_stamp_r  <= press_stamp_nxt;
      vl_reported_r  <= vl_reported_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/button_press_classifier.sv
// button debounce with short, long and very-long press classification
// depends on bpc_pkg, bpc_channels, bpc_cfg_regs, bpc_classify
//
//   channel   direction  payload                                          
//   in_chan   sink       raw_level, now_time                              
//   out_chan  source     short_press, long_press, very_long_press, stable_level
//   cfg_*     write      cfg_wr_en, cfg_index, cfg_wr_data                
//
// one sample per cycle sustained while results are taken; a taken sample passes through the
// sample register, then one pass of the classifier into the result register
// synchronous active-low reset restores default thresholds and a released button
// a held result stalls the classifier, and the sample register refills as it drains
`default_nettype none
`include "button_press_classifier_defines.svh"

module button_press_classifier (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  bpc_in_if.sink                             in_chan,
  bpc_out_if.source                          out_chan,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bpc_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [bpc_pkg::CfgDataW-1:0]  cfg_wr_data
);
  import bpc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t out_item_r;
  out_item_t result;
  logic      out_valid_r;
  logic      step;
  logic      in_take;
  logic [2:0] ev_flags;
  logic      rel_ev_out;
  logic      very_ev_out;

  assign step           = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !in_valid_r || step;
  assign in_take        = in_chan.valid && in_chan.ready;

  bpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_wr_data),
    .cfg      (cfg)
  );

  bpc_classify u_classify (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .cfg    (cfg),
    .item   (in_item_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.raw_level <= in_chan.raw_level;
      in_item_r.now_time  <= in_chan.now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= result;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.short_press     = out_item_r.short_press;
  assign out_chan.long_press      = out_item_r.long_press;
  assign out_chan.very_long_press = out_item_r.very_long_press;
  assign out_chan.stable_level    = out_item_r.stable_level;

  assign ev_flags = {out_item_r.short_press, out_item_r.long_press,
                     out_item_r.very_long_press};
  assign rel_ev_out  = out_valid_r && (out_item_r.short_press || out_item_r.long_press);
  assign very_ev_out = out_valid_r && out_item_r.very_long_press;

  `BPC_ASSERT_SAME(a_one_event, out_valid_r, $onehot0(ev_flags), "more than one press event")
  `BPC_ASSERT_SAME(a_release_level, rel_ev_out, !out_item_r.stable_level, "release while pressed")
  `BPC_ASSERT_SAME(a_very_level, very_ev_out, out_item_r.stable_level, "very-long while released")
  `BPC_ASSERT_NEXT(a_step_result, step, out_valid_r, "classified sample not presented")

endmodule

`default_nettype wire

>>> tb/sv/bpc_press_checker.sv
// watches the sample and result channels of the button press classifier,
// predicts every result word and compares it; depends on bpc_pkg and bpc_channels
`default_nettype none

module bpc_press_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  bpc_in_if                                  in_chan,
  bpc_out_if                                 out_chan,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bpc_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [bpc_pkg::CfgDataW-1:0]  cfg_wr_data,
  output int unsigned                        fail_count,
  output int unsigned                        words_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  cfg_t             thresholds;
  logic             seen_raw;
  logic             stable;
  logic             very_long_sent;
  logic [TimeW-1:0] raw_changed_at;
  logic [TimeW-1:0] pressed_at;
  out_item_t        predicted_flags[$];

  initial fail_count = 0;

  function automatic out_item_t classify_sample(input in_item_t s);
    out_item_t        r;
    logic [TimeW-1:0] since_change;
    logic [TimeW-1:0] held;
    r = '0;
    if (s.raw_level != seen_raw) begin
      seen_raw       = s.raw_level;
      raw_changed_at = s.now_time;
    end
    since_change = s.now_time - raw_changed_at;
    if (since_change >= TimeW'(thresholds.debounce_time) && stable != seen_raw) begin
      stable = seen_raw;
      if (stable) begin
        pressed_at     = s.now_time;
        very_long_sent = 1'b0;
      end else if (!very_long_sent) begin
        held = s.now_time - pressed_at;
        if (held >= TimeW'(thresholds.long_press_time)) begin
          r.long_press = 1'b1;
        end else begin
          r.short_press = 1'b1;
        end
      end
    end
    held = s.now_time - pressed_at;
    if (stable && !very_long_sent && held >= TimeW'(thresholds.very_long_press_time)) begin
      very_long_sent    = 1'b1;
      r.very_long_press = 1'b1;
    end
    r.stable_level = stable;
    return r;
  endfunction

  task automatic check_flag(input string field, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    in_item_t  sample;
    out_item_t want;
    if (!rst_n) begin
      thresholds     = '{DEBOUNCE_RESET, LONG_RESET, VERY_LONG_RESET};
      seen_raw       = 1'b0;
      stable         = 1'b0;
      very_long_sent = 1'b0;
      raw_changed_at = '0;
      pressed_at     = '0;
      predicted_flags.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_DEBOUNCE:  thresholds.debounce_time        = cfg_wr_data[DebW-1:0];
          CFG_LONG:      thresholds.long_press_time      = cfg_wr_data[LongW-1:0];
          CFG_VERY_LONG: thresholds.very_long_press_time = cfg_wr_data[VeryW-1:0];
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        sample.raw_level = in_chan.raw_level;
        sample.now_time  = in_chan.now_time;
        predicted_flags.push_back(classify_sample(sample));
      end
      if (out_chan.valid && out_chan.ready) begin
        if (predicted_flags.size() == 0) begin
          $error("result word with no prediction pending");
          fail_count++;
        end else begin
          want = predicted_flags.pop_front();
          check_flag("short_press", want.short_press, out_chan.short_press);
          check_flag("long_press", want.long_press, out_chan.long_press);
          check_flag("very_long_press", want.very_long_press, out_chan.very_long_press);
          check_flag("stable_level", want.stable_level, out_chan.stable_level);
        end
      end
    end
    words_pending = predicted_flags.size();
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_button_press_classifier.sv
// top of the button press classifier testbench: clock, reset, sample and
// threshold stimulus, result sink and verdict; depends on bpc_pkg, bpc_channels, bpc_press_checker
`default_nettype none

module tb_button_press_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  localparam logic [CfgIndexW-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_WORDS  = 280;
  localparam int unsigned PHASE_COUNT  = 6;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_wr_data;

  int unsigned fail_count;
  int unsigned words_pending;
  int unsigned cycle_count;
  int unsigned phase_words;
  int unsigned rx_hold_req;
  bit          tx_idle_on;
  bit          rx_idle_on;
  logic [TimeW-1:0] ms_now;

  bpc_in_if  in_chan ();
  bpc_out_if out_chan ();

  button_press_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  bpc_press_checker press_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .out_chan     (out_chan),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .words_pending(words_pending)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result sink: random stall per word, or a long hold-off when requested
  initial begin : result_sink
    int unsigned stall;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 9) : 0;
      if (rx_hold_req != 0) begin
        stall       = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  task automatic send_sample(input logic raw, input logic [TimeW-1:0] stamp);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.raw_level <= raw;
    in_chan.now_time  <= stamp;
    do @(posedge clk); while (!in_chan.ready);
    phase_words++;
  endtask

  task automatic send_step(input logic raw, input int unsigned dt);
    ms_now = ms_now + dt;
    send_sample(raw, ms_now);
  endtask

  // sender pauses until every predicted word has come back
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input int unsigned deb, input int unsigned lng,
                              input int unsigned very);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_DEBOUNCE;
    cfg_wr_data <= {4'($urandom), 16'(deb)};
    @(posedge clk);
    cfg_index   <= CFG_LONG;
    cfg_wr_data <= {4'($urandom), 16'(lng)};
    @(posedge clk);
    cfg_index   <= CFG_VERY_LONG;
    cfg_wr_data <= 20'(very);
    @(posedge clk);
    // unmapped index must leave all thresholds alone
    cfg_index   <= CFG_UNUSED;
    cfg_wr_data <= 20'($urandom);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // chatter shorter than the debounce time, ending on the wanted level
  task automatic bounce(input logic level, input int unsigned deb);
    repeat ($urandom_range(0, 3)) begin
      send_step(level, deb == 0 ? 0 : $urandom_range(0, deb - 1));
      send_step(!level, deb == 0 ? 0 : $urandom_range(0, deb - 1));
    end
    send_step(level, deb == 0 ? 0 : $urandom_range(0, deb - 1));
    send_step(level, (deb != 0 && $urandom_range(0, 1)) ? deb - 1 : deb);
    send_step(level, $urandom_range(0, 3));
  endtask

  task automatic press_cycle(input int unsigned deb, input int unsigned lng,
                             input int unsigned very);
    int unsigned hold;
    int unsigned k;
    case ($urandom_range(0, 2))
      0:       hold = $urandom_range(0, lng);
      1:       hold = $urandom_range(lng, very);
      default: hold = very + $urandom_range(0, deb + 20);
    endcase
    bounce(1'b1, deb);
    k = $urandom_range(1, 6);
    repeat (k) send_step(1'b1, hold / k + $urandom_range(0, 2));
    bounce(1'b0, deb);
    repeat ($urandom_range(0, 2)) send_step(1'b0, $urandom_range(0, deb + 5));
  endtask

  in_item_t opening[] = '{
    '{1'b0, 32'd0},          '{1'b1, 32'd10},         '{1'b1, 32'd20},
    '{1'b1, 32'd35},         '{1'b0, 32'd40},         '{1'b1, 32'd45},
    '{1'b1, 32'd70},         '{1'b0, 32'd100},        '{1'b0, 32'd125},
    '{1'b1, 32'd200},        '{1'b1, 32'd225},        '{1'b0, 32'd950},
    '{1'b0, 32'd975},        '{1'b1, 32'd2000},       '{1'b1, 32'd2025},
    '{1'b1, 32'd5024},       '{1'b1, 32'd5025},       '{1'b0, 32'd5100},
    '{1'b0, 32'd5125},       '{1'b1, 32'hFFFF_FFF0},  '{1'b1, 32'h0000_0009},
    '{1'b0, 32'hFFFF_FFFF},  '{1'b0, 32'd24}
  };

  initial begin : stimulus
    int unsigned deb;
    int unsigned lng;
    int unsigned very;
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.raw_level <= 1'b0;
    in_chan.now_time  <= '0;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= CFG_DEBOUNCE;
    cfg_wr_data       <= '0;
    rx_hold_req = 0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    phase_words = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default thresholds: bounce, short, long at its edge, very-long, wrap
    foreach (opening[i]) send_sample(opening[i].raw_level, opening[i].now_time);
    drain();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin deb = 0;     lng = 0;     very = 0;       end
        1: begin deb = 65535; lng = 65535; very = 1048575; end
        default: begin
          deb  = $urandom_range(0, 40);
          lng  = $urandom_range(0, 300);
          very = $urandom_range(0, 1000);
        end
      endcase
      program_regs(deb, lng, very);
      ms_now      = $urandom();
      phase_words = 0;
      if (p == 2) begin
        // stop the sink for a long stretch and keep feeding words
        rx_hold_req = 150;
        tx_idle_on  = 1'b0;
        press_cycle(deb, lng, very);
        press_cycle(deb, lng, very);
      end
      while (phase_words < PHASE_WORDS) begin
        if ($urandom_range(0, 7) == 0) begin
          tx_idle_on = ($urandom_range(0, 3) != 0);
          rx_idle_on = ($urandom_range(0, 3) != 0);
        end
        case ($urandom_range(0, 9))
          0: begin
            ms_now = $urandom();
            send_sample(1'($urandom), ms_now);
          end
          1: send_step(1'($urandom), -$urandom_range(0, 50));
          default: press_cycle(deb, lng, very);
        endcase
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
